/* rtl/core/ualc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualc_pkg: shared types and constants of the unroutable address check
// Prefix tables, register indexes and the record that passes from the
// classifier through the queue to the accumulator.
// ----------------------------------------------------------------------------
package ualc_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LOOPBACK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_RESERVED = 8'd1;

  // Depth of the queue between classifier and accumulator.
  localparam int QUEUE_DEPTH = 2;

  // IPv4-mapped addresses carry this tag in bits 63..32 of the lower half.
  localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_ffff;

  // Reserved IPv4 prefixes and their lengths.
  localparam int V4_PREFIXES = 8;
  localparam logic [31:0] V4_NET [V4_PREFIXES] = '{
    32'h0a00_0000, 32'hac10_0000, 32'hc0a8_0000, 32'ha9fe_0000,
    32'hc000_0200, 32'hc633_6400, 32'hcb00_7100, 32'hc012_0000
  };
  localparam int V4_LEN [V4_PREFIXES] = '{8, 12, 16, 16, 24, 24, 24, 15};

  // First octets of the IPv4 zero network and loopback network.
  localparam logic [7:0] V4_ZERO_NET = 8'h00;
  localparam logic [7:0] V4_LOOP_NET = 8'h7f;

  // IPv6 reserved prefixes, aligned to the top of the upper half.
  localparam logic [27:0] V6_ORCHID     = 28'h2001001;
  localparam logic [31:0] V6_DOC        = 32'h2001_0db8;
  localparam logic [9:0]  V6_LINK_LOCAL = 10'h3fa;
  localparam logic [9:0]  V6_SITE_LOCAL = 10'h3fb;

  // Per-address verdict handed to the accumulator.
  typedef struct packed {
    logic hit;
    logic last;
  } ualc_item_t;

  // Prefix mask for a constant prefix length.
  function automatic logic [31:0] v4_mask(input int len);
    v4_mask = 32'hffff_ffff << (32 - len);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ualc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualc_if: channel interfaces of the unroutable address check
// Address request channel, verdict channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ualc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] addr_upper;
  logic [63:0] addr_lower;
  logic        last_of_list;

  modport source (output valid, output addr_upper, output addr_lower,
                  output last_of_list, input ready);
  modport sink (input valid, input addr_upper, input addr_lower,
                input last_of_list, output ready);
endinterface

interface ualc_out_if;
  logic valid;
  logic ready;
  logic address_unroutable;
  logic all_unroutable;
  logic list_end;

  modport source (output valid, output address_unroutable, output all_unroutable,
                  output list_end, input ready);
  modport sink (input valid, input address_unroutable, input all_unroutable,
                input list_end, output ready);
endinterface

interface ualc_cfg_if;
  import ualc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/ualc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualc_front: address classifier
// Holds the check enables, accepts address requests and tests each address
// against the enabled classes with parallel prefix comparators.
// ----------------------------------------------------------------------------
module ualc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  ualc_in_if.sink               in_if,
  ualc_cfg_if.sink              cfg_if,
  output ualc_pkg::ualc_item_t  push_item,
  output logic                  push_valid,
  input  wire logic             push_ready
);
  import ualc_pkg::*;

  logic check_loopback_r, check_loopback_nxt;
  logic check_reserved_r, check_reserved_nxt;
  logic is_mapped;
  logic [31:0] v4_addr;
  logic [V4_PREFIXES-1:0] v4_hits;
  logic v4_hit;
  logic v6_hit;

  // Configuration writes are always taken.
  assign cfg_if.ready = 1'b1;

  always_comb begin
    check_loopback_nxt = check_loopback_r;
    check_reserved_nxt = check_reserved_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_CHECK_LOOPBACK: check_loopback_nxt = cfg_if.data;
        CFG_CHECK_RESERVED: check_reserved_nxt = cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_loopback_r <= 1'b0;
      check_reserved_r <= 1'b0;
    end else begin
      check_loopback_r <= check_loopback_nxt;
      check_reserved_r <= check_reserved_nxt;
    end
  end

  // An IPv4-mapped address is tested only against the IPv4 classes.
  assign is_mapped = (in_if.addr_upper == 64'd0) &&
                     (in_if.addr_lower[63:32] == V4_MAPPED_TAG);
  assign v4_addr   = in_if.addr_lower[31:0];

  // One comparator per reserved IPv4 prefix.
  always_comb begin
    for (int i = 0; i < V4_PREFIXES; i++) begin
      v4_hits[i] = (v4_addr & v4_mask(V4_LEN[i])) == (V4_NET[i] & v4_mask(V4_LEN[i]));
    end
  end

  assign v4_hit = (check_reserved_r && (|v4_hits)) ||
                  (check_loopback_r && ((v4_addr[31:24] == V4_ZERO_NET) ||
                                        (v4_addr[31:24] == V4_LOOP_NET)));

  // Native IPv6 classes: reserved prefixes and the ::1 loopback.
  assign v6_hit = (check_reserved_r &&
                   ((in_if.addr_upper[63:36] == V6_ORCHID) ||
                    (in_if.addr_upper[63:32] == V6_DOC) ||
                    (in_if.addr_upper[63:54] == V6_LINK_LOCAL) ||
                    (in_if.addr_upper[63:54] == V6_SITE_LOCAL))) ||
                  (check_loopback_r && (in_if.addr_upper == 64'd0) &&
                   (in_if.addr_lower == 64'd1));

  // Verdicts go straight into the queue.
  assign in_if.ready    = push_ready;
  assign push_valid     = in_if.valid;
  assign push_item.hit  = is_mapped ? v4_hit : v6_hit;
  assign push_item.last = in_if.last_of_list;

endmodule
`default_nettype wire

/* rtl/core/ualc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualc_queue: verdict queue
// Short first-in first-out buffer between classifier and accumulator so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module ualc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ualc_pkg::ualc_item_t  push_item,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  output ualc_pkg::ualc_item_t       pop_item,
  output logic                       pop_valid,
  input  wire logic                  pop_ready
);
  import ualc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  ualc_item_t slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ualc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualc_back: list accumulator and result register
// ANDs the verdicts of the current list, rearms after the last address and
// holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module ualc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ualc_pkg::ualc_item_t  pop_item,
  input  wire logic                  pop_valid,
  output logic                       pop_ready,
  ualc_out_if.source                 out_if
);
  import ualc_pkg::*;

  logic all_so_far_r, all_so_far_nxt;
  logic out_valid_r, out_valid_nxt;
  logic hit_r, acc_r, last_r;
  logic acc;
  logic do_pop;

  // The result register refills whenever it is empty or being emptied.
  assign pop_ready = !out_valid_r || out_if.ready;
  assign do_pop    = pop_valid && pop_ready;
  assign acc       = all_so_far_r & pop_item.hit;

  always_comb begin
    all_so_far_nxt = all_so_far_r;
    out_valid_nxt  = out_valid_r;
    if (do_pop) begin
      all_so_far_nxt = pop_item.last ? 1'b1 : acc;
      out_valid_nxt  = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_so_far_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      all_so_far_r <= all_so_far_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      hit_r  <= pop_item.hit;
      acc_r  <= acc;
      last_r <= pop_item.last;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.address_unroutable = hit_r;
  assign out_if.all_unroutable     = acc_r;
  assign out_if.list_end           = last_r;

endmodule
`default_nettype wire

/* rtl/core/unroutable_address_list_check.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unroutable_address_list_check: top level
// Classifies a list of IPv6 or IPv4-mapped addresses as unroutable and keeps
// a running verdict over each list.
//
//   Channel  Direction  Carries
//   in_if    sink       addr_upper, addr_lower, last_of_list
//   out_if   source     address_unroutable, all_unroutable, list_end
//   cfg_if   sink       index, data (0: check_loopback, 1: check_reserved)
//
// One address per cycle is sustained while out_if takes each result. Each
// verdict enters the queue when its request is accepted and moves on into the
// result register, which offers it. Reset clears the check enables and rearms
// the list verdict. A stalled result leaves the two-entry queue to absorb
// requests, after which in_if.ready drops. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module unroutable_address_list_check (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ualc_in_if.sink    in_if,
  ualc_out_if.source out_if,
  ualc_cfg_if.sink   cfg_if
);
  import ualc_pkg::*;

  ualc_item_t push_item, pop_item;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;

  ualc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  ualc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  ualc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_if    (out_if)
  );

endmodule
`default_nettype wire
